### rtl/sctan_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sctan_pkg
// Shared constants and types for the sine, cosine and tangent unit.
// ----------------------------------------------------------------------------
package sctan_pkg;

  localparam int TERMS_DEF = 5;
  localparam int QDEPTH_DEF = 4;
  localparam int DIV_STEPS = 32;

  // Angles in unsigned Q32 radians.
  localparam logic [47:0] TWO_PI        = 48'd26986075409;
  localparam logic [47:0] THREE_HALF_PI = 48'd20239556557;
  localparam logic [47:0] PI            = 48'd13493037704;
  localparam logic [47:0] HALF_PI       = 48'd6746518852;
  localparam logic [32:0] SMALL_ANGLE   = 33'd21474836;
  localparam logic [32:0] PEAK_ANGLE    = 33'd6742223885;
  localparam logic [31:0] ONE_Q30       = 32'd1073741824;

  // Reciprocal of 2*pi, scaled by 2^20, for the quotient estimate.
  localparam logic [17:0] INV_TWO_PI = 18'((64'd1 << 52) / 64'(TWO_PI));

  localparam logic [1:0] OP_SIN   = 2'd0;
  localparam logic [1:0] OP_COS   = 2'd1;
  localparam logic [1:0] OP_TAN   = 2'd2;
  localparam logic [1:0] OP_UNDEF = 2'd3;

  // Folded angles of the sine and cosine lanes, handed from front to back.
  typedef struct packed {
    logic [1:0]  opcode;
    logic        s_neg;
    logic [32:0] s_f;
    logic        c_neg;
    logic [32:0] c_f;
  } item_t;

endpackage
`default_nettype wire

### rtl/sctan_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sctan_front
// Takes in words, reduces both lanes modulo 2*pi and folds them by quadrant.
// ----------------------------------------------------------------------------
module sctan_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                valid,
  output logic                     stall,
  input  wire logic signed [31:0]  angle,
  input  wire logic [1:0]          opcode,
  input  wire logic                q_full,
  output logic                     item_valid,
  output sctan_pkg::item_t         item
);

  logic en;

  logic        av;
  logic [1:0]  a_op;
  logic [47:0] a_s;
  logic [48:0] a_c;
  logic [47:0] a32;
  logic [48:0] ac;

  logic        mv;
  logic [1:0]  m_op;
  logic        m_sneg;
  logic [47:0] m_s;
  logic        m_cneg;
  logic [47:0] m_c;

  logic        qv;
  logic [1:0]  q_op;
  logic        q_sneg;
  logic [47:0] q_ms;
  logic [13:0] q_s;
  logic        q_cneg;
  logic [47:0] q_mc;
  logic [13:0] q_c;

  logic        rv;
  logic [1:0]  r_op;
  logic        r_sneg;
  logic [36:0] r_s;
  logic        r_cneg;
  logic [36:0] r_c;

  logic        cv;
  logic [1:0]  c_op;
  logic        c_sneg;
  logic [34:0] c_s;
  logic        c_cneg;
  logic [34:0] c_c;

  logic fv;
  sctan_pkg::item_t fold;
  sctan_pkg::item_t fold_next;

  function automatic logic [47:0] abs48(input logic [47:0] v);
    return v[47] ? (~v + 48'd1) : v;
  endfunction

  function automatic logic [48:0] abs49(input logic [48:0] v);
    return v[48] ? (~v + 49'd1) : v;
  endfunction

  // The estimate never exceeds the true quotient and is at most two below it.
  function automatic logic [13:0] quot_est(input logic [47:0] m);
    logic [45:0] p;
    begin
      p = 46'(m[47:20]) * 46'(sctan_pkg::INV_TWO_PI);
      return p[45:32];
    end
  endfunction

  function automatic logic [36:0] rem_est(input logic [47:0] m, input logic [13:0] q);
    logic [48:0] prod;
    logic [47:0] r;
    begin
      prod = 49'(q) * 49'(sctan_pkg::TWO_PI);
      r = m - prod[47:0];
      return r[36:0];
    end
  endfunction

  function automatic logic [34:0] rem_fix(input logic [36:0] r);
    logic [36:0] t1;
    logic [36:0] t2;
    logic [36:0] v;
    begin
      t1 = 37'(sctan_pkg::TWO_PI);
      t2 = t1 << 1;
      if (r >= t2) begin
        v = r - t2;
      end else if (r >= t1) begin
        v = r - t1;
      end else begin
        v = r;
      end
      return v[34:0];
    end
  endfunction

  function automatic logic [33:0] fold_lane(input logic neg, input logic [47:0] r);
    logic [47:0] f;
    logic n;
    begin
      n = neg;
      if (r < sctan_pkg::HALF_PI) begin
        f = r;
      end else if (r < sctan_pkg::PI) begin
        f = sctan_pkg::PI - r;
      end else if (r < sctan_pkg::THREE_HALF_PI) begin
        f = r - sctan_pkg::PI;
        n = ~neg;
      end else begin
        f = sctan_pkg::TWO_PI - r;
        n = ~neg;
      end
      return {n, f[32:0]};
    end
  endfunction

  assign en = !fv || !q_full;
  assign stall = !en;

  assign a32 = {angle, 16'h0000};
  assign ac = {a32[47], a32} + {1'b0, sctan_pkg::HALF_PI};

  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
    end else if (en) begin
      av <= valid;
    end
    if (en) begin
      a_op <= opcode;
      a_s  <= a32;
      a_c  <= ac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (en) begin
      mv <= av;
    end
    if (en) begin
      m_op   <= a_op;
      m_sneg <= a_s[47];
      m_s    <= abs48(a_s);
      m_cneg <= a_c[48];
      m_c    <= abs49(a_c)[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= 1'b0;
    end else if (en) begin
      qv <= mv;
    end
    if (en) begin
      q_op   <= m_op;
      q_sneg <= m_sneg;
      q_ms   <= m_s;
      q_s    <= quot_est(m_s);
      q_cneg <= m_cneg;
      q_mc   <= m_c;
      q_c    <= quot_est(m_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (en) begin
      rv <= qv;
    end
    if (en) begin
      r_op   <= q_op;
      r_sneg <= q_sneg;
      r_s    <= rem_est(q_ms, q_s);
      r_cneg <= q_cneg;
      r_c    <= rem_est(q_mc, q_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
    end else if (en) begin
      cv <= rv;
    end
    if (en) begin
      c_op   <= r_op;
      c_sneg <= r_sneg;
      c_s    <= rem_fix(r_s);
      c_cneg <= r_cneg;
      c_c    <= rem_fix(r_c);
    end
  end

  always_comb begin
    fold_next.opcode = c_op;
    {fold_next.s_neg, fold_next.s_f} = fold_lane(c_sneg, 48'(c_s));
    {fold_next.c_neg, fold_next.c_f} = fold_lane(c_cneg, 48'(c_c));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (en) begin
      fv <= cv;
    end
    if (en) begin
      fold <= fold_next;
    end
  end

  assign item_valid = fv;
  assign item = fold;

endmodule
`default_nettype wire

### rtl/sctan_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sctan_queue
// Short queue of folded words between the front and back pipelines.
// ----------------------------------------------------------------------------
module sctan_queue #(
  parameter int DEPTH = sctan_pkg::QDEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire sctan_pkg::item_t  wr_item,
  input  wire logic              pop,
  output logic                   full,
  output logic                   not_empty,
  output sctan_pkg::item_t       rd_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sctan_pkg::item_t mem [0:DEPTH-1];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;

  assign full = (cnt == CW'(DEPTH));
  assign not_empty = (cnt != '0);
  assign rd_item = mem[rd_ptr];

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + CW'(1);
    end else if (pop && !push) begin
      cnt_next = cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (cnt == $past(cnt) + CW'(1)))
    else $error("queue count lost a word");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

### rtl/sctan_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sctan_back
// Horner polynomial on both lanes, tangent divider and result register.
// ----------------------------------------------------------------------------
module sctan_back #(
  parameter int TERMS = sctan_pkg::TERMS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire sctan_pkg::item_t  item,
  output logic                   pop,
  output logic                   value_valid,
  input  wire logic              value_stall,
  output logic signed [31:0]     value,
  output logic                   saturated
);

  localparam int H = TERMS - 1;
  localparam int D = sctan_pkg::DIV_STEPS;

  typedef struct packed {
    logic        neg;
    logic        small_f;
    logic        peak;
    logic [30:0] xq;
    logic [31:0] xsq;
    logic [32:0] y;
  } lane_t;

  typedef struct packed {
    logic [1:0] opcode;
    lane_t      s;
    lane_t      c;
  } hrn_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] sin_q16;
    logic [31:0] cos_q16;
    logic        sneg;
    logic        neg;
    logic        czero;
    logic        ovf;
    logic [31:0] cm;
    logic [47:0] r;
    logic [31:0] q;
  } div_t;

  logic en;

  logic hv [0:H];
  hrn_t hr [0:H];

  logic        pv;
  logic [1:0]  p_op;
  logic [32:0] p_s;
  logic [32:0] p_c;

  logic dv [0:D];
  div_t dq [0:D];
  div_t d0_next;

  logic [31:0] val_next;
  logic        sat_next;

  function automatic logic [32:0] coef(input int idx);
    logic signed [32:0] c;
    begin
      unique case (idx)
        0:       c = 33'sd1073741824;
        1:       c = -33'sd178956971;
        2:       c = 33'sd8947849;
        3:       c = -33'sd213044;
        4:       c = 33'sd2959;
        5:       c = -33'sd27;
        default: c = 33'sd0;
      endcase
      return c;
    end
  endfunction

  // Signed Q30 times unsigned, rounded half up on the magnitude.
  function automatic logic [32:0] mul_q30(input logic [32:0] a, input logic [31:0] b);
    logic        neg;
    logic [32:0] ua;
    logic [63:0] p;
    logic [32:0] m;
    begin
      neg = a[32];
      ua = neg ? (~a + 33'd1) : a;
      p = 64'(ua[31:0]) * 64'(b);
      p = (p + 64'd536870912) >> 30;
      m = p[32:0];
      return neg ? (~m + 33'd1) : m;
    end
  endfunction

  function automatic lane_t lane_init(input logic neg, input logic [32:0] f);
    logic [32:0] xw;
    logic [63:0] sq;
    lane_t l;
    begin
      xw = (f + 33'd2) >> 2;
      sq = 64'(xw[30:0]) * 64'(xw[30:0]);
      sq = (sq + 64'd536870912) >> 30;
      l.neg = neg;
      l.small_f = (f < sctan_pkg::SMALL_ANGLE);
      l.peak = (f > sctan_pkg::PEAK_ANGLE);
      l.xq = xw[30:0];
      l.xsq = sq[31:0];
      l.y = coef(TERMS - 1);
      return l;
    end
  endfunction

  function automatic logic [32:0] lane_out(input lane_t l);
    logic [32:0] b;
    begin
      if (l.small_f) begin
        b = {2'b00, l.xq};
      end else if (l.peak) begin
        b = {1'b0, sctan_pkg::ONE_Q30};
      end else begin
        b = mul_q30(l.y, {1'b0, l.xq});
      end
      return l.neg ? (~b + 33'd1) : b;
    end
  endfunction

  function automatic logic [31:0] q30_to_q16(input logic [32:0] v);
    logic [32:0] mag;
    logic [32:0] m2;
    begin
      mag = v[32] ? (~v + 33'd1) : v;
      m2 = (mag + 33'd8192) >> 14;
      return v[32] ? (~m2[31:0] + 32'd1) : m2[31:0];
    end
  endfunction

  assign en = !value_valid || !value_stall;
  assign pop = item_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      hv[0] <= 1'b0;
    end else if (en) begin
      hv[0] <= item_valid;
    end
    if (en) begin
      hr[0].opcode <= item.opcode;
      hr[0].s <= lane_init(item.s_neg, item.s_f);
      hr[0].c <= lane_init(item.c_neg, item.c_f);
    end
  end

  // One Horner step per stage, highest coefficient first.
  for (genvar h = 0; h < H; h++) begin : g_hrn
    hrn_t stage_next;
    always_comb begin
      stage_next = hr[h];
      stage_next.s.y = coef(TERMS - 2 - h) + mul_q30(hr[h].s.y, hr[h].s.xsq);
      stage_next.c.y = coef(TERMS - 2 - h) + mul_q30(hr[h].c.y, hr[h].c.xsq);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        hv[h+1] <= 1'b0;
      end else if (en) begin
        hv[h+1] <= hv[h];
      end
      if (en) begin
        hr[h+1] <= stage_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= hv[H];
    end
    if (en) begin
      p_op <= hr[H].opcode;
      p_s  <= lane_out(hr[H].s);
      p_c  <= lane_out(hr[H].c);
    end
  end

  always_comb begin
    logic [32:0] sa;
    logic [32:0] ca;
    logic [47:0] dd;
    sa = p_s[32] ? (~p_s + 33'd1) : p_s;
    ca = p_c[32] ? (~p_c + 33'd1) : p_c;
    dd = {sa[31:0], 16'h0000} + 48'(ca[31:1]);
    d0_next.opcode  = p_op;
    d0_next.sin_q16 = q30_to_q16(p_s);
    d0_next.cos_q16 = q30_to_q16(p_c);
    d0_next.sneg    = p_s[32];
    d0_next.neg     = p_s[32] ^ p_c[32];
    d0_next.czero   = (p_c == '0);
    d0_next.cm      = ca[31:0];
    d0_next.ovf     = ({16'h0000, dd} >= {ca[31:0], 32'h0});
    d0_next.r       = dd;
    d0_next.q       = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= pv;
    end
    if (en) begin
      dq[0] <= d0_next;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar j = 0; j < D; j++) begin : g_div
    localparam int B = D - 1 - j;
    logic [63:0] sh;
    logic        ge;
    div_t        stage_next;
    assign sh = {32'h0, dq[j].cm} << B;
    assign ge = ({16'h0000, dq[j].r} >= sh);
    always_comb begin
      stage_next = dq[j];
      stage_next.r = ge ? (dq[j].r - sh[47:0]) : dq[j].r;
      stage_next.q[B] = ge;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else if (en) begin
        dv[j+1] <= dv[j];
      end
      if (en) begin
        dq[j+1] <= stage_next;
      end
    end
  end

  always_comb begin
    val_next = '0;
    sat_next = 1'b0;
    unique case (dq[D].opcode)
      sctan_pkg::OP_SIN: val_next = dq[D].sin_q16;
      sctan_pkg::OP_COS: val_next = dq[D].cos_q16;
      sctan_pkg::OP_TAN: begin
        if (dq[D].czero) begin
          val_next = dq[D].sneg ? 32'h80000000 : 32'h7FFFFFFF;
          sat_next = 1'b1;
        end else if (dq[D].ovf || (!dq[D].neg && dq[D].q[31]) ||
                     (dq[D].neg && dq[D].q > 32'h80000000)) begin
          val_next = dq[D].neg ? 32'h80000000 : 32'h7FFFFFFF;
          sat_next = 1'b1;
        end else begin
          val_next = dq[D].neg ? (~dq[D].q + 32'd1) : dq[D].q;
        end
      end
      default: begin
        val_next = '0;
        sat_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_valid <= 1'b0;
    end else if (en) begin
      value_valid <= dv[D];
    end
    if (en) begin
      value     <= val_next;
      saturated <= sat_next;
    end
  end

endmodule
`default_nettype wire

### rtl/sine_cosine_tangent_approx_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sine_cosine_tangent_approx_top
// Fixed-point sine, cosine and tangent of a Q15.16 angle in radians.
// ----------------------------------------------------------------------------
// An input word (angle, opcode) is taken when valid is high and stall is low.
// Opcode 0 gives sine, 1 cosine, 2 tangent; the result word (value, saturated)
// leaves on value_valid / value_stall, one result for every input word.
// Both channels take one word per clock when not stalled, so the sustained
// rate is one word per cycle.
// The front reduces the angle modulo 2*pi with a reciprocal quotient
// estimate and one correction step. The back holds the Horner stages and
// the 32 stages of the tangent divider, which produce one quotient bit each.
// A four-word queue sits between front and back. When the receiver stalls,
// the back pipeline holds, the queue fills, and then stall is raised to the
// sender. A synchronous reset empties every stage and the queue; no word is
// in flight afterwards.
// ----------------------------------------------------------------------------
module sine_cosine_tangent_approx_top #(
  parameter int TERMS  = sctan_pkg::TERMS_DEF,
  parameter int QDEPTH = sctan_pkg::QDEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               valid,
  output logic                    stall,
  input  wire logic signed [31:0] angle,
  input  wire logic [1:0]         opcode,
  output logic                    value_valid,
  input  wire logic               value_stall,
  output logic signed [31:0]      value,
  output logic                    saturated
);

  logic             q_full;
  logic             q_not_empty;
  logic             f_valid;
  logic             q_pop;
  sctan_pkg::item_t f_item;
  sctan_pkg::item_t q_item;

  sctan_front u_front (
    .clk        (clk),
    .rst        (rst),
    .valid      (valid),
    .stall      (stall),
    .angle      (angle),
    .opcode     (opcode),
    .q_full     (q_full),
    .item_valid (f_valid),
    .item       (f_item)
  );

  sctan_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid && !q_full),
    .wr_item   (f_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rd_item   (q_item)
  );

  sctan_back #(
    .TERMS (TERMS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (q_not_empty),
    .item        (q_item),
    .pop         (q_pop),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .saturated   (saturated)
  );

endmodule
`default_nettype wire
